[rtl/core/nim_pkg.sv]
// shared types, constants and codes of the nearest index matcher
package nim_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SCAN_LIMIT      = 64;

    localparam int SLOT_W  = 6;
    localparam int VALUE_W = 12;
    localparam int DIST_W  = 16;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST  = 7'd0;
    localparam logic [CNT_W-1:0]  MAX_MATCHES_RST  = 7'd8;
    localparam logic [DIST_W-1:0] MATCH_WINDOW_RST = 16'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCHES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_WINDOW = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [SLOT_W-1:0]  entry_slot;
        logic [VALUE_W-1:0] entry_value;
        logic [DIST_W-1:0]  query_value;
    } t_in_word;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] match_slot;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic              vld;
        logic [DIST_W-1:0] distance;
        logic [SLOT_W-1:0] slot;
    } t_cell;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_cell    cand;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

[rtl/core/nim_ram.sv]
// generic single write port ram with registered read
module nim_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/nim_cell.sv]
// one cell of the sorted candidate chain
module nim_cell
    import nim_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_cell     i_left,
    input  logic      i_left_ins,
    input  t_cell     i_right,
    output t_cell     o_cell,
    output logic      o_ins
);

    t_cell r_cell;
    t_cell n_cell;

    // strict compare keeps the older, lower slot ahead on equal distance
    assign o_ins = !r_cell.vld || (r_cell.distance > i_ctl.cand.distance);

    always_comb begin
        n_cell = r_cell;
        case (i_ctl.op)
            CELL_CLEAR: begin
                n_cell.vld = 1'b0;
            end
            CELL_INSERT: begin
                if (o_ins) begin
                    n_cell = i_left_ins ? i_left : i_ctl.cand;
                end
            end
            CELL_SHIFT: begin
                n_cell = i_right;
            end
            default: begin
                n_cell = r_cell;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
        end else begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[rtl/core/nearest_index_matcher_core.sv]
// top level of the nearest index matcher: control, table ram and cell chain
//
// Usage:
//   Input words arrive on i_in_valid / o_in_ready. A load word (cmd 0) writes
//   entry_value into table slot entry_slot and gives no output. A query word
//   (cmd 1) scans the first n slots, n = entry_count capped at the chain
//   length, one table read per cycle through the single ram read port; each
//   distance is inserted into a chain of sorted cells. Then the chain shifts
//   out one result word per cycle while i_out_ready holds, on o_out_valid /
//   i_out_ready, nearest first, lower slot first on equal distance, last
//   flagged. A query with nothing in range gives one word with found 0.
//   Input words are taken only while no query is in progress; a finished
//   result may still sit in the output register meanwhile.
//   When the receiver stalls, the output register holds its word and the
//   chain waits. Reset returns the control to idle and the registers to
//   entry_count 0, max_matches 8, match_window 480. The table is not cleared:
//   only slots written since reset may take part in a query, which the user
//   must ensure; the block does not check it. The user must write the
//   registers over i_cfg_we / i_cfg_idx / i_cfg_wdata only while idle; the
//   block does not enforce this.
module nearest_index_matcher_core
    import nim_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int NUM_CELLS = (TABLE_DEPTH < SCAN_LIMIT) ? TABLE_DEPTH : SCAN_LIMIT;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(NUM_CELLS + 1);

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]   r_entry_count;
    logic [CNT_W-1:0]   r_max_matches;
    logic [DIST_W-1:0]  r_match_window;

    logic [DIST_W-1:0]  r_query;
    logic [CW-1:0]      r_scan_n;
    logic [CW-1:0]      r_rd_cnt;
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_slot;
    logic               r_cand_vld;
    logic [DIST_W-1:0]  r_cand_dist;
    logic [SLOT_W-1:0]  r_cand_slot;
    logic [CNT_W-1:0]   r_emit_cnt;
    logic               r_out_vld;
    t_out_word          r_out_word;

    logic               w_in_acc;
    logic               w_query_acc;
    logic               w_load_we;
    logic [VALUE_W-1:0] w_rd_data;
    logic [DIST_W-1:0]  w_ref;
    logic [DIST_W-1:0]  w_dist;
    logic [CW-1:0]      w_eff_n;
    logic               w_rd_issue;
    logic               w_scan_done;
    logic               w_out_free;
    logic               w_emit_go;
    logic               w_emit_hit;
    logic               w_next_hit;
    logic               w_emit_last;
    t_out_word          w_emit_word;
    t_cell_ctl          w_ctl;

    t_cell              w_cells [NUM_CELLS];
    logic               w_ins   [NUM_CELLS];

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_query_acc = w_in_acc && (i_in_word.cmd == CMD_QUERY);
    assign w_load_we   = w_in_acc && (i_in_word.cmd == CMD_LOAD)
                         && (32'(i_in_word.entry_slot) < TABLE_DEPTH);

    assign w_eff_n = (32'(r_entry_count) > NUM_CELLS) ? CW'(NUM_CELLS) : CW'(r_entry_count);

    nim_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (AW'(i_in_word.entry_slot)),
        .i_wdata (i_in_word.entry_value),
        .i_raddr (AW'(r_rd_cnt)),
        .o_rdata (w_rd_data)
    );

    // table values are integers, the query carries four fraction bits
    assign w_ref  = {w_rd_data, 4'b0000};
    assign w_dist = (r_query >= w_ref) ? (r_query - w_ref) : (w_ref - r_query);

    // sorted chain, cell 0 holds the nearest candidate
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        t_cell w_left;
        logic  w_left_ins;
        t_cell w_right;

        if (g == 0) begin : g_head
            assign w_left     = '0;
            assign w_left_ins = 1'b0;
        end else begin : g_mid
            assign w_left     = w_cells[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == NUM_CELLS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_cells[g+1];
        end

        nim_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .o_cell     (w_cells[g]),
            .o_ins      (w_ins[g])
        );
    end

    assign w_out_free = !r_out_vld || i_out_ready;

    assign w_emit_hit = w_cells[0].vld && (w_cells[0].distance <= r_match_window)
                        && (r_emit_cnt < r_max_matches);
    assign w_next_hit = w_cells[1].vld && (w_cells[1].distance <= r_match_window)
                        && ((8'(r_emit_cnt) + 8'd1) < 8'(r_max_matches));
    assign w_emit_last = !w_emit_hit || !w_next_hit;

    assign w_rd_issue  = (r_state == S_SCAN) && (r_rd_cnt < r_scan_n);
    assign w_scan_done = (r_state == S_SCAN) && !w_rd_issue && !r_rd_vld && !r_cand_vld;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_query_acc) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free && w_emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        w_ctl.op            = CELL_HOLD;
        w_ctl.cand.vld      = 1'b1;
        w_ctl.cand.distance = r_cand_dist;
        w_ctl.cand.slot     = r_cand_slot;
        w_emit_go           = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_query_acc) begin
                    w_ctl.op = CELL_CLEAR;
                end
            end
            S_SCAN: begin
                if (r_cand_vld) begin
                    w_ctl.op = CELL_INSERT;
                end
            end
            S_EMIT: begin
                w_emit_go = w_out_free;
                if (w_out_free) begin
                    w_ctl.op = CELL_SHIFT;
                end
            end
            default: begin
                w_ctl.op = CELL_HOLD;
            end
        endcase
    end

    always_comb begin
        w_emit_word.found      = w_emit_hit;
        w_emit_word.match_slot = w_emit_hit ? w_cells[0].slot : '0;
        w_emit_word.distance   = w_emit_hit ? w_cells[0].distance : '0;
        w_emit_word.last       = w_emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_entry_count  <= ENTRY_COUNT_RST;
            r_max_matches  <= MAX_MATCHES_RST;
            r_match_window <= MATCH_WINDOW_RST;
            r_scan_n       <= '0;
            r_rd_cnt       <= '0;
            r_rd_vld       <= 1'b0;
            r_cand_vld     <= 1'b0;
            r_emit_cnt     <= '0;
            r_out_vld      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENTRY_COUNT:  r_entry_count  <= i_cfg_wdata[CNT_W-1:0];
                    CFG_MAX_MATCHES:  r_max_matches  <= i_cfg_wdata[CNT_W-1:0];
                    CFG_MATCH_WINDOW: r_match_window <= i_cfg_wdata[DIST_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_query_acc) begin
                r_scan_n   <= w_eff_n;
                r_rd_cnt   <= '0;
                r_emit_cnt <= '0;
            end else if (w_rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end

            r_rd_vld   <= w_rd_issue;
            r_cand_vld <= r_rd_vld;

            if (w_emit_go && w_emit_hit) begin
                r_emit_cnt <= r_emit_cnt + 1'b1;
            end

            if (w_emit_go) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_query_acc) begin
            r_query <= i_in_word.query_value;
        end
        r_rd_slot   <= SLOT_W'(r_rd_cnt);
        r_cand_slot <= r_rd_slot;
        r_cand_dist <= w_dist;
        if (w_emit_go) begin
            r_out_word <= w_emit_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cells[1].vld |->
            (w_cells[0].vld && (w_cells[0].distance <= w_cells[1].distance)))
        else $error("candidate chain out of order");

    a_nomatch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> o_out_word.last)
        else $error("no-match word not marked last");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_emit_cnt <= r_max_matches))
        else $error("more matches than max_matches");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_cnt <= r_scan_n))
        else $error("table scan ran past entry count");

endmodule
